[hdl/tft_pkg.sv]
// shared types and constants for the tftp flow tracker
package tft_pkg;

   localparam int DEFAULT_ENTRIES = 16;
   localparam logic [7:0] UDP_PROTOCOL = 8'd17;
   localparam logic [15:0] DEFAULT_REQUEST_PORT = 16'd69;

   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 4;

   typedef enum logic [2:0] {
      ACT_IGNORED   = 3'd0,
      ACT_STORED    = 3'd1,
      ACT_COMPLETED = 3'd2,
      ACT_COUNTED   = 3'd3,
      ACT_NO_MATCH  = 3'd4,
      ACT_FULL      = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_RESOLVE,
      ST_PURGE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] client_addr;
      logic [31:0] server_addr;
      logic [15:0] client_port;
      logic [15:0] server_port;
      logic [31:0] packets_seen;
   } entry_type;

   typedef struct packed {
      logic load;
      logic cnt_zero;
      logic clr_step;
      logic scan_step;
      logic resolve;
      logic purge_step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic in_udp;
      logic cnt_end;
      logic clear_end;
      logic purge_needed;
      logic out_free;
   } status_type;

endpackage

[hdl/tft_ctrl.sv]
// sequencer for clear, scan, update and purge passes
module tft_ctrl
   import tft_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clear_end) begin
               cmd.cnt_zero = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = status.in_udp ? ST_SCAN : ST_EMIT;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.cnt_end) begin
               cmd.cnt_zero = 1'b1;
               state_in     = ST_RESOLVE;
            end
         end
         ST_RESOLVE: begin
            cmd.resolve = 1'b1;
            state_in    = status.purge_needed ? ST_PURGE : ST_EMIT;
         end
         ST_PURGE: begin
            cmd.purge_step = 1'b1;
            if (status.cnt_end) begin
               cmd.cnt_zero = 1'b1;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

[hdl/tft_datapath.sv]
// flow table memory, key compare, hit tracking and result registers
module tft_datapath
   import tft_pkg::*;
#(
   parameter int ENTRIES = DEFAULT_ENTRIES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser,
   input  logic                  csr_wr_en,
   input  logic [15:0]           csr_wr_data
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);

   entry_type entry_mem_ff [ENTRIES];
   entry_type rd_data_ff;

   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_dec;
   logic [IDX_W-1:0] rd_addr, cmp_idx;
   logic             rd_en;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;

   logic [15:0] req_port_ff, req_port_in;

   logic        req_mode_ff, req_mode_in;
   logic        is_req_ff, is_req_in;
   logic [31:0] sip_ff, sip_in, dip_ff, dip_in;
   logic [15:0] sp_ff, sp_in, dp_ff, dp_in;

   logic             hit_a_ff, hit_a_in, hit_f_ff, hit_f_in, hit_c_ff, hit_c_in;
   logic [IDX_W-1:0] idx_a_ff, idx_a_in, idx_f_ff, idx_f_in, idx_c_ff, idx_c_in;
   logic [31:0]      cnt_a_ff, cnt_a_in, cnt_c_ff, cnt_c_in;
   logic             fwd_c_ff, fwd_c_in;

   action_type  res_action_ff, res_action_in;
   logic        res_belongs_ff, res_belongs_in;
   logic [3:0]  res_slot_ff, res_slot_in;
   logic [31:0] res_total_ff, res_total_in;

   logic        rsp_valid_ff, rsp_valid_in;
   action_type  rsp_action_ff, rsp_action_in;
   logic        rsp_belongs_ff, rsp_belongs_in;
   logic [3:0]  rsp_slot_ff, rsp_slot_in;
   logic [31:0] rsp_total_ff, rsp_total_in;

   logic        cmp_en, m_pend, m_free, m_comp, m_fwd, m_rev, m_dup;
   logic [31:0] cnt_sel, total_inc;
   entry_type   req_word;

   logic [7:0]  in_proto;
   logic [31:0] in_sip, in_dip;
   logic [15:0] in_sp, in_dp;

   assign in_proto = req_tdata[7:0];
   assign in_sip   = req_tdata[39:8];
   assign in_dip   = req_tdata[71:40];
   assign in_sp    = req_tdata[87:72];
   assign in_dp    = req_tdata[103:88];

   assign cnt_dec = cnt_ff - CNT_W'(1);
   assign cmp_idx = cnt_dec[IDX_W-1:0];
   assign rd_addr = cnt_ff[IDX_W-1:0];
   assign rd_en   = (cmd.scan_step || cmd.purge_step) && (cnt_ff < CNT_W'(ENTRIES));
   assign cmp_en  = (cmd.scan_step || cmd.purge_step) && (cnt_ff != '0);

   // per-entry compares against the held header
   always_comb begin
      m_pend = rd_data_ff.valid && rd_data_ff.client_addr == sip_ff &&
               rd_data_ff.server_addr == dip_ff && rd_data_ff.client_port == sp_ff &&
               rd_data_ff.server_port == '0;
      m_free = !rd_data_ff.valid;
      m_comp = rd_data_ff.valid && rd_data_ff.server_port == '0 &&
               rd_data_ff.server_addr == sip_ff && rd_data_ff.client_addr == dip_ff &&
               rd_data_ff.client_port == dp_ff;
      m_fwd  = rd_data_ff.client_addr == sip_ff && rd_data_ff.server_addr == dip_ff &&
               rd_data_ff.client_port == sp_ff && rd_data_ff.server_port == dp_ff;
      m_rev  = rd_data_ff.server_addr == sip_ff && rd_data_ff.client_addr == dip_ff &&
               rd_data_ff.server_port == sp_ff && rd_data_ff.client_port == dp_ff;
      // duplicate of the entry just completed
      m_dup  = rd_data_ff.valid && m_rev && cmp_idx != idx_a_ff;
   end

   // saturating count for the winning entry
   assign cnt_sel   = hit_a_ff ? cnt_a_ff : cnt_c_ff;
   assign total_inc = (cnt_sel == '1) ? cnt_sel : cnt_sel + 32'd1;

   assign req_word = '{valid: 1'b1, client_addr: sip_ff, server_addr: dip_ff,
                       client_port: sp_ff, server_port: 16'd0, packets_seen: 32'd1};

   always_comb begin
      cnt_in         = cnt_ff;
      req_port_in    = req_port_ff;
      req_mode_in    = req_mode_ff;
      is_req_in      = is_req_ff;
      sip_in         = sip_ff;
      dip_in         = dip_ff;
      sp_in          = sp_ff;
      dp_in          = dp_ff;
      hit_a_in       = hit_a_ff;
      hit_f_in       = hit_f_ff;
      hit_c_in       = hit_c_ff;
      idx_a_in       = idx_a_ff;
      idx_f_in       = idx_f_ff;
      idx_c_in       = idx_c_ff;
      cnt_a_in       = cnt_a_ff;
      cnt_c_in       = cnt_c_ff;
      fwd_c_in       = fwd_c_ff;
      res_action_in  = res_action_ff;
      res_belongs_in = res_belongs_ff;
      res_slot_in    = res_slot_ff;
      res_total_in   = res_total_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_action_in  = rsp_action_ff;
      rsp_belongs_in = rsp_belongs_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_total_in   = rsp_total_ff;
      wr_en          = 1'b0;
      wr_addr        = rd_addr;
      wr_data        = '0;

      if (csr_wr_en) begin
         req_port_in = csr_wr_data;
      end

      if (cmd.cnt_zero) begin
         cnt_in = '0;
      end else if (cmd.clr_step || cmd.scan_step || cmd.purge_step) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end

      if (cmd.clr_step) begin
         wr_en   = 1'b1;
         wr_addr = rd_addr;
         wr_data = '0;
      end

      if (cmd.load) begin
         req_mode_in    = req_tuser && (in_dp == req_port_ff);
         is_req_in      = req_tuser;
         sip_in         = in_sip;
         dip_in         = in_dip;
         sp_in          = in_sp;
         dp_in          = in_dp;
         hit_a_in       = 1'b0;
         hit_f_in       = 1'b0;
         hit_c_in       = 1'b0;
         res_action_in  = ACT_IGNORED;
         res_belongs_in = 1'b0;
         res_slot_in    = '0;
         res_total_in   = '0;
      end

      if (cmd.scan_step && cmp_en) begin
         if (req_mode_ff) begin
            if (m_pend && !hit_a_ff) begin
               hit_a_in = 1'b1;
               idx_a_in = cmp_idx;
            end
            if (m_free && !hit_f_ff) begin
               hit_f_in = 1'b1;
               idx_f_in = cmp_idx;
            end
         end else begin
            if (m_comp && !hit_a_ff) begin
               hit_a_in = 1'b1;
               idx_a_in = cmp_idx;
               cnt_a_in = rd_data_ff.packets_seen;
            end
            if (rd_data_ff.valid && (m_fwd || m_rev) && !hit_c_ff) begin
               hit_c_in = 1'b1;
               idx_c_in = cmp_idx;
               cnt_c_in = rd_data_ff.packets_seen;
               fwd_c_in = m_fwd;
            end
         end
      end

      if (cmd.resolve) begin
         res_belongs_in = 1'b1;
         if (req_mode_ff) begin
            if (hit_a_ff || hit_f_ff) begin
               wr_en         = 1'b1;
               wr_addr       = hit_a_ff ? idx_a_ff : idx_f_ff;
               wr_data       = req_word;
               res_action_in = ACT_STORED;
               res_slot_in   = 4'(wr_addr);
               res_total_in  = 32'd1;
            end else begin
               res_action_in = ACT_FULL;
            end
         end else if (hit_a_ff) begin
            wr_en         = 1'b1;
            wr_addr       = idx_a_ff;
            wr_data       = '{valid: 1'b1, client_addr: dip_ff, server_addr: sip_ff,
                              client_port: dp_ff, server_port: sp_ff,
                              packets_seen: total_inc};
            res_action_in = ACT_COMPLETED;
            res_slot_in   = 4'(idx_a_ff);
            res_total_in  = total_inc;
         end else if (hit_c_ff) begin
            wr_en   = 1'b1;
            wr_addr = idx_c_ff;
            if (fwd_c_ff) begin
               wr_data = '{valid: 1'b1, client_addr: sip_ff, server_addr: dip_ff,
                           client_port: sp_ff, server_port: dp_ff,
                           packets_seen: total_inc};
            end else begin
               wr_data = '{valid: 1'b1, client_addr: dip_ff, server_addr: sip_ff,
                           client_port: dp_ff, server_port: sp_ff,
                           packets_seen: total_inc};
            end
            res_action_in = ACT_COUNTED;
            res_slot_in   = 4'(idx_c_ff);
            res_total_in  = total_inc;
         end else begin
            res_action_in  = ACT_NO_MATCH;
            res_belongs_in = is_req_ff;
         end
      end

      // drop any other entry that now carries the completed key
      if (cmd.purge_step && cmp_en && m_dup) begin
         wr_en         = 1'b1;
         wr_addr       = cmp_idx;
         wr_data       = rd_data_ff;
         wr_data.valid = 1'b0;
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in   = 1'b1;
         rsp_action_in  = res_action_ff;
         rsp_belongs_in = res_belongs_ff;
         rsp_slot_in    = res_slot_ff;
         rsp_total_in   = res_total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         req_port_ff  <= DEFAULT_REQUEST_PORT;
         hit_a_ff     <= 1'b0;
         hit_f_ff     <= 1'b0;
         hit_c_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         req_port_ff  <= req_port_in;
         hit_a_ff     <= hit_a_in;
         hit_f_ff     <= hit_f_in;
         hit_c_ff     <= hit_c_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_mode_ff    <= req_mode_in;
      is_req_ff      <= is_req_in;
      sip_ff         <= sip_in;
      dip_ff         <= dip_in;
      sp_ff          <= sp_in;
      dp_ff          <= dp_in;
      idx_a_ff       <= idx_a_in;
      idx_f_ff       <= idx_f_in;
      idx_c_ff       <= idx_c_in;
      cnt_a_ff       <= cnt_a_in;
      cnt_c_ff       <= cnt_c_in;
      fwd_c_ff       <= fwd_c_in;
      res_action_ff  <= res_action_in;
      res_belongs_ff <= res_belongs_in;
      res_slot_ff    <= res_slot_in;
      res_total_ff   <= res_total_in;
      rsp_action_ff  <= rsp_action_in;
      rsp_belongs_ff <= rsp_belongs_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_total_ff   <= rsp_total_in;
   end

   assign status.in_udp       = (in_proto == UDP_PROTOCOL);
   assign status.cnt_end      = (cnt_ff == CNT_W'(ENTRIES));
   assign status.clear_end    = (cnt_ff == CNT_W'(ENTRIES - 1));
   assign status.purge_needed = !req_mode_ff && hit_a_ff;
   assign status.out_free     = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_total_ff, rsp_slot_ff};
   assign rsp_tuser  = {rsp_belongs_ff, rsp_action_ff};

endmodule

[hdl/tftp_flow_tracker_unit.sv]
// top level of the tftp flow tracker: controller plus table datapath
// a udp header is scanned against every entry, then resolved and emitted; when a pending
// entry completes, a duplicate purge pass runs before the emit; a non-udp header skips both
// the scan reads one entry per cycle through the single read port of the table memory,
// and a new header is accepted only after the previous result has been emitted
// reset: synchronous; afterwards a clearing pass empties every entry of the table
// and req_tready stays low until it ends, csr writes are taken throughout
module tftp_flow_tracker_unit
   import tft_pkg::*;
#(
   parameter int ENTRIES = DEFAULT_ENTRIES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // ip_protocol[7:0], source_ip[39:8], dest_ip[71:40], source_port[87:72],
   // dest_port[103:88]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // is_request[0]
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // slot[3:0], packet_total[35:4], zero[39:36]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // action[2:0], belongs[3]
   output logic [RSP_USER_W-1:0] rsp_tuser,
   input  logic                  csr_wr_en,
   input  logic [15:0]           csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   tft_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tft_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

endmodule

[hdl/tft_checker.sv]
// port-level checks for the tftp flow tracker, bound to the top level
module tft_checker
   import tft_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [RSP_USER_W-1:0] rsp_tuser
);

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   // table is being cleared right after reset
   a_clear_blocks: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("input taken during clearing pass");

   a_ignored_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:0] == ACT_IGNORED |-> !rsp_tuser[3] && rsp_tdata == '0)
      else $error("ignored word carries data");

   a_stored_one: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:0] == ACT_STORED |-> rsp_tuser[3] && rsp_tdata[35:4] == 32'd1)
      else $error("stored request count is not one");

   a_counted_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[2:0] == ACT_COUNTED || rsp_tuser[2:0] == ACT_COMPLETED)
      |-> rsp_tuser[3] && rsp_tdata[35:4] > 32'd1)
      else $error("matched entry count too small");

endmodule

bind tftp_flow_tracker_unit tft_checker u_tft_checker (.*);
